/* design/kaf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the Kalman angle fusion block.
// No dependencies; all files but kaf_checker refer to it by scoped names.

package kaf_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_PROC_NOISE_ANGLE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROC_NOISE_BIAS  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEAS_NOISE       = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD    = 4'd3;

    // Reset values of the configuration registers (unsigned Q8.24).
    localparam logic [CFG_DATA_W-1:0] RST_PROC_NOISE_ANGLE = 32'd16777;
    localparam logic [CFG_DATA_W-1:0] RST_PROC_NOISE_BIAS  = 32'd50332;
    localparam logic [CFG_DATA_W-1:0] RST_MEAS_NOISE       = 32'd8388608;
    localparam logic [CFG_DATA_W-1:0] RST_SAMPLE_PERIOD    = 32'd83886;

    // One in Q8.24, the reset value of the diagonal covariance terms.
    localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

    // Saturation input width and the signed 32-bit limits at that width.
    localparam int SAT_W = 48;
    localparam logic signed [SAT_W-1:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [SAT_W-1:0] SAT_MIN = 48'shFFFF_8000_0000;

    // Divider: one overflow-detect step plus 32 quotient bits.
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Step counter for the multiply sequences.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] PRED_LAST = 3'd5;
    localparam logic [STEP_W-1:0] CORR_LAST = 3'd7;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RATE_DT,
        MUL_PDOT_DT,
        MUL_CBB_DT,
        MUL_PNB_DT,
        MUL_K0_P00,
        MUL_K0_P01,
        MUL_K1_P00,
        MUL_K1_P01,
        MUL_K0_ERR,
        MUL_K1_ERR
    } mul_sel_t;

    // Where a rounded product is accumulated, and with which sign.
    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_ANGLE,
        ACC_P00,
        ACC_P01_P10,
        ACC_P11,
        ACC_CAA,
        ACC_CAB,
        ACC_CBA,
        ACC_CBB,
        ACC_BIAS
    } acc_sel_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_sel_t acc_sel;
    } seq_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     prep;
        mul_sel_t mul_sel;
        acc_sel_t acc_sel;
        logic     calc_err;
        logic     div_load;
        logic     div_step;
        logic     gain_load;
        logic     out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } status_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = signed'(v[31:0]);
        end
        return r;
    endfunction

    // Predict sequence. A product issued at one step passes through the multiplier
    // register and then the rounding register before it is accumulated at a later step.
    function automatic seq_op_t pred_op(input logic [STEP_W-1:0] step);
        seq_op_t op;
        op.mul_sel = MUL_NONE;
        op.acc_sel = ACC_NONE;
        case (step)
            3'd0: op.mul_sel = MUL_RATE_DT;
            3'd1: op.mul_sel = MUL_PDOT_DT;
            3'd2:
            begin
                op.mul_sel = MUL_CBB_DT;
                op.acc_sel = ACC_ANGLE;
            end
            3'd3:
            begin
                op.mul_sel = MUL_PNB_DT;
                op.acc_sel = ACC_P00;
            end
            3'd4: op.acc_sel = ACC_P01_P10;
            3'd5: op.acc_sel = ACC_P11;
            default: ;
        endcase
        return op;
    endfunction

    // Correction sequence, with the same path through the multiplier and rounding registers.
    function automatic seq_op_t corr_op(input logic [STEP_W-1:0] step);
        seq_op_t op;
        op.mul_sel = MUL_NONE;
        op.acc_sel = ACC_NONE;
        case (step)
            3'd0: op.mul_sel = MUL_K0_P00;
            3'd1: op.mul_sel = MUL_K0_P01;
            3'd2:
            begin
                op.mul_sel = MUL_K1_P00;
                op.acc_sel = ACC_CAA;
            end
            3'd3:
            begin
                op.mul_sel = MUL_K1_P01;
                op.acc_sel = ACC_CAB;
            end
            3'd4:
            begin
                op.mul_sel = MUL_K0_ERR;
                op.acc_sel = ACC_CBA;
            end
            3'd5:
            begin
                op.mul_sel = MUL_K1_ERR;
                op.acc_sel = ACC_CBB;
            end
            3'd6: op.acc_sel = ACC_ANGLE;
            3'd7: op.acc_sel = ACC_BIAS;
            default: ;
        endcase
        return op;
    endfunction

endpackage

/* design/kalman_angle_fusion_top.sv */
`timescale 1ns / 1ps
// Top level of the Kalman angle fusion block: controller plus datapath.
// Depends on kaf_pkg, kaf_ctrl and kaf_dp.
//
// Two-state Kalman filter that fuses an accelerometer angle with a gyro rate
// and tracks the gyro bias. Angles and rates are signed Q16.16, the four
// configuration registers (process noise of angle and bias, measurement
// noise, sample period) are unsigned Q8.24 and are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while the block is
// idle, as the block does not enforce it; indexes above 3 are ignored. Each
// accepted request produces exactly one result request with the fused angle
// and the bias-corrected rate, both saturated. One sample is processed at a
// time, and a 33-step two-lane gain divider dominates its processing time,
// with the rest spent in a shared 33x33 multiplier followed by a rounding
// stage and a saturating accumulator. A finished result waits in an output
// register, so a new request is taken while the previous result is unclaimed.

module kalman_angle_fusion_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [kaf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [kaf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [31:0]               accel_angle,
    input  logic signed [31:0]               gyro_rate,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [31:0]               angle_estimate,
    output logic signed [31:0]               rate_estimate
);

    kaf_pkg::cmd_t    cmd;
    kaf_pkg::status_t status;

    // Sequencer.
    kaf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and state.
    kaf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .accel_angle    (accel_angle),
        .gyro_rate      (gyro_rate),
        .cmd            (cmd),
        .status         (status),
        .angle_estimate (angle_estimate),
        .rate_estimate  (rate_estimate)
    );

endmodule

/* design/kaf_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine for the Kalman angle fusion block.
// Depends on kaf_pkg for the command, status and step-sequence definitions.

module kaf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  kaf_pkg::status_t status,
    output kaf_pkg::cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_PRED  = 9'b000000100,
        S_ERR   = 9'b000001000,
        S_DIVLD = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_GAIN  = 9'b001000000,
        S_CORR  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [kaf_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;
    kaf_pkg::seq_op_t             op;

    // Next state and command decode.
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        op.mul_sel    = kaf_pkg::MUL_NONE;
        op.acc_sel    = kaf_pkg::ACC_NONE;
        cmd.load_in   = 1'b0;
        cmd.prep      = 1'b0;
        cmd.calc_err  = 1'b0;
        cmd.div_load  = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.gain_load = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = S_PRED;
            end
            S_PRED:
            begin
                op = kaf_pkg::pred_op(step_reg);
                if (step_reg == kaf_pkg::PRED_LAST)
                begin
                    step_next  = '0;
                    state_next = S_ERR;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_ERR:
            begin
                cmd.calc_err = 1'b1;
                state_next   = S_DIVLD;
            end
            S_DIVLD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_GAIN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_GAIN:
            begin
                cmd.gain_load = 1'b1;
                step_next     = '0;
                state_next    = S_CORR;
            end
            S_CORR:
            begin
                op = kaf_pkg::corr_op(step_reg);
                if (step_reg == kaf_pkg::CORR_LAST)
                begin
                    step_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                // Wait here only while an earlier result is still unclaimed.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.mul_sel = op.mul_sel;
        cmd.acc_sel = op.acc_sel;
    end

    // Output request flag.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* design/kaf_div.sv */
`timescale 1ns / 1ps
// Two-lane restoring divider that forms both Kalman gains with a shared divisor.
// Depends on kaf_pkg for the step count and the step counter width.

module kaf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               step,
    input  logic signed [33:0] den,
    input  logic signed [31:0] num0,
    input  logic signed [31:0] num1,
    output logic               done,
    output logic signed [31:0] quo0,
    output logic signed [31:0] quo1
);

    logic [kaf_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [64:0]                   dsh_reg, dsh_next;
    logic [55:0]                   rem0_reg, rem0_next;
    logic [55:0]                   rem1_reg, rem1_next;
    logic [32:0]                   q0_reg, q0_next;
    logic [32:0]                   q1_reg, q1_next;
    logic                          zero_reg, zero_next;
    logic                          neg0_reg, neg0_next;
    logic                          neg1_reg, neg1_next;

    logic signed [33:0] den_neg;
    logic [32:0]        den_mag;
    logic signed [31:0] num0_neg, num1_neg;
    logic [31:0]        num0_mag, num1_mag;
    logic               cmp0, cmp1;

    // Turn a quotient magnitude and sign into a clamped signed result.
    function automatic logic signed [31:0] clamp_quo(input logic [32:0] q,
                                                    input logic neg);
        logic signed [31:0] r;
        if (neg)
        begin
            if (q > 33'h0_8000_0000)
            begin
                r = 32'sh8000_0000;
            end
            else
            begin
                r = -signed'(q[31:0]);
            end
        end
        else
        begin
            if (q > 33'h0_7FFF_FFFF)
            begin
                r = 32'sh7FFF_FFFF;
            end
            else
            begin
                r = signed'(q[31:0]);
            end
        end
        return r;
    endfunction

    // Operand magnitudes for the sign-magnitude division.
    assign den_neg  = -den;
    assign den_mag  = den[33] ? den_neg[32:0] : den[32:0];
    assign num0_neg = -num0;
    assign num1_neg = -num1;
    assign num0_mag = num0[31] ? unsigned'(num0_neg) : unsigned'(num0);
    assign num1_mag = num1[31] ? unsigned'(num1_neg) : unsigned'(num1);

    // Trial subtraction against the shifted divisor, one quotient bit per lane.
    assign cmp0 = ({9'b0, rem0_reg} >= dsh_reg);
    assign cmp1 = ({9'b0, rem1_reg} >= dsh_reg);

    always_comb
    begin
        cnt_next  = cnt_reg;
        dsh_next  = dsh_reg;
        rem0_next = rem0_reg;
        rem1_next = rem1_reg;
        q0_next   = q0_reg;
        q1_next   = q1_reg;
        zero_next = zero_reg;
        neg0_next = neg0_reg;
        neg1_next = neg1_reg;
        if (load)
        begin
            // The first step only tests for a quotient of 2^32 or more.
            cnt_next  = kaf_pkg::DIV_CNT_W'(kaf_pkg::DIV_STEPS);
            dsh_next  = {den_mag, 32'b0};
            rem0_next = {num0_mag, 24'b0};
            rem1_next = {num1_mag, 24'b0};
            q0_next   = '0;
            q1_next   = '0;
            zero_next = (den == '0);
            neg0_next = num0[31] ^ den[33];
            neg1_next = num1[31] ^ den[33];
        end
        else if (step)
        begin
            cnt_next = cnt_reg - 1'b1;
            dsh_next = dsh_reg >> 1;
            q0_next  = {q0_reg[31:0], cmp0};
            q1_next  = {q1_reg[31:0], cmp1};
            if (cmp0)
            begin
                rem0_next = rem0_reg - dsh_reg[55:0];
            end
            if (cmp1)
            begin
                rem1_next = rem1_reg - dsh_reg[55:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsh_reg  <= dsh_next;
        rem0_reg <= rem0_next;
        rem1_reg <= rem1_next;
        q0_reg   <= q0_next;
        q1_reg   <= q1_next;
        zero_reg <= zero_next;
        neg0_reg <= neg0_next;
        neg1_reg <= neg1_next;
    end

    // A zero innovation variance gives zero gains.
    assign done = (cnt_reg == '0);
    assign quo0 = zero_reg ? 32'sd0 : clamp_quo(q0_reg, neg0_reg);
    assign quo1 = zero_reg ? 32'sd0 : clamp_quo(q1_reg, neg1_reg);

endmodule

/* design/kaf_dp.sv */
`timescale 1ns / 1ps
// Datapath of the Kalman angle fusion block: configuration, filter state,
// shared multiplier with rounding stage, saturating accumulator and divider.
// Depends on kaf_pkg and kaf_div.

module kaf_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [kaf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kaf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic signed [31:0]                 accel_angle,
    input  logic signed [31:0]                 gyro_rate,
    input  kaf_pkg::cmd_t                      cmd,
    output kaf_pkg::status_t                   status,
    output logic signed [31:0]                 angle_estimate,
    output logic signed [31:0]                 rate_estimate
);

    // Configuration registers.
    logic [31:0] pna_reg, pnb_reg, mn_reg, dt_reg;

    // Filter state.
    logic signed [31:0] angle_reg, angle_next;
    logic signed [31:0] bias_reg, bias_next;
    logic signed [31:0] caa_reg, caa_next;
    logic signed [31:0] cab_reg, cab_next;
    logic signed [31:0] cba_reg, cba_next;
    logic signed [31:0] cbb_reg, cbb_next;

    // Per-sample working registers.
    logic signed [31:0] accel_reg, gyro_reg;
    logic signed [31:0] rate_reg, pdot_reg, err_reg;
    logic signed [31:0] p00_reg, p00_next;
    logic signed [31:0] p01_reg, p01_next;
    logic signed [31:0] p10_reg, p10_next;
    logic signed [31:0] p11_reg, p11_next;
    logic signed [31:0] k0_reg, k1_reg;
    logic signed [33:0] e_reg;
    logic signed [65:0] prod_reg, prod_next;
    logic signed [41:0] rnd_reg;
    logic signed [31:0] angle_out_reg, rate_out_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] rnd_sum;
    logic signed [31:0] acc_base;
    logic               acc_sub;
    logic signed [43:0] acc_sum;
    logic signed [43:0] acc_sum2;
    logic signed [31:0] acc_val, acc_val2;
    logic signed [31:0] rate_diff;
    logic signed [31:0] quo0, quo1;
    logic               div_done;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pna_reg <= kaf_pkg::RST_PROC_NOISE_ANGLE;
            pnb_reg <= kaf_pkg::RST_PROC_NOISE_BIAS;
            mn_reg  <= kaf_pkg::RST_MEAS_NOISE;
            dt_reg  <= kaf_pkg::RST_SAMPLE_PERIOD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kaf_pkg::CFG_PROC_NOISE_ANGLE: pna_reg <= cfg_wdata;
                kaf_pkg::CFG_PROC_NOISE_BIAS:  pnb_reg <= cfg_wdata;
                kaf_pkg::CFG_MEAS_NOISE:       mn_reg  <= cfg_wdata;
                kaf_pkg::CFG_SAMPLE_PERIOD:    dt_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            kaf_pkg::MUL_RATE_DT:
            begin
                mul_a = 33'(rate_reg);
                mul_b = signed'({1'b0, dt_reg});
            end
            kaf_pkg::MUL_PDOT_DT:
            begin
                mul_a = 33'(pdot_reg);
                mul_b = signed'({1'b0, dt_reg});
            end
            kaf_pkg::MUL_CBB_DT:
            begin
                mul_a = 33'(cbb_reg);
                mul_b = signed'({1'b0, dt_reg});
            end
            kaf_pkg::MUL_PNB_DT:
            begin
                mul_a = signed'({1'b0, pnb_reg});
                mul_b = signed'({1'b0, dt_reg});
            end
            kaf_pkg::MUL_K0_P00:
            begin
                mul_a = 33'(k0_reg);
                mul_b = 33'(p00_reg);
            end
            kaf_pkg::MUL_K0_P01:
            begin
                mul_a = 33'(k0_reg);
                mul_b = 33'(p01_reg);
            end
            kaf_pkg::MUL_K1_P00:
            begin
                mul_a = 33'(k1_reg);
                mul_b = 33'(p00_reg);
            end
            kaf_pkg::MUL_K1_P01:
            begin
                mul_a = 33'(k1_reg);
                mul_b = 33'(p01_reg);
            end
            kaf_pkg::MUL_K0_ERR:
            begin
                mul_a = 33'(k0_reg);
                mul_b = 33'(err_reg);
            end
            kaf_pkg::MUL_K1_ERR:
            begin
                mul_a = 33'(k1_reg);
                mul_b = 33'(err_reg);
            end
            default: ;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Shift right by 24 with rounding half away from zero.
    assign rnd_sum = prod_reg + (prod_reg[65] ? 66'sd8388607 : 66'sd8388608);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rnd_reg  <= signed'(rnd_sum[65:24]);
    end

    // Saturating accumulate of the rounded product into its destination.
    always_comb
    begin
        acc_base = angle_reg;
        acc_sub  = 1'b0;
        case (cmd.acc_sel)
            kaf_pkg::ACC_ANGLE:   acc_base = angle_reg;
            kaf_pkg::ACC_P00:     acc_base = caa_reg;
            kaf_pkg::ACC_P01_P10:
            begin
                acc_base = cab_reg;
                acc_sub  = 1'b1;
            end
            kaf_pkg::ACC_P11:     acc_base = cbb_reg;
            kaf_pkg::ACC_CAA:
            begin
                acc_base = p00_reg;
                acc_sub  = 1'b1;
            end
            kaf_pkg::ACC_CAB:
            begin
                acc_base = p01_reg;
                acc_sub  = 1'b1;
            end
            kaf_pkg::ACC_CBA:
            begin
                acc_base = p10_reg;
                acc_sub  = 1'b1;
            end
            kaf_pkg::ACC_CBB:
            begin
                acc_base = p11_reg;
                acc_sub  = 1'b1;
            end
            kaf_pkg::ACC_BIAS:    acc_base = bias_reg;
            default: ;
        endcase
    end

    assign acc_sum  = acc_sub ? (44'(acc_base) - 44'(rnd_reg))
                              : (44'(acc_base) + 44'(rnd_reg));
    assign acc_val  = kaf_pkg::sat32(48'(acc_sum));
    // The cross-covariance terms share one product in the predict step.
    assign acc_sum2 = 44'(cba_reg) - 44'(rnd_reg);
    assign acc_val2 = kaf_pkg::sat32(48'(acc_sum2));

    // Bias-corrected rate, used in the predict step and for the result.
    assign rate_diff = kaf_pkg::sat32(48'(gyro_reg) - 48'(bias_reg));

    // Next values of state and predicted covariance.
    always_comb
    begin
        angle_next = angle_reg;
        bias_next  = bias_reg;
        caa_next   = caa_reg;
        cab_next   = cab_reg;
        cba_next   = cba_reg;
        cbb_next   = cbb_reg;
        p00_next   = p00_reg;
        p01_next   = p01_reg;
        p10_next   = p10_reg;
        p11_next   = p11_reg;
        case (cmd.acc_sel)
            kaf_pkg::ACC_ANGLE:   angle_next = acc_val;
            kaf_pkg::ACC_P00:     p00_next   = acc_val;
            kaf_pkg::ACC_P01_P10:
            begin
                p01_next = acc_val;
                p10_next = acc_val2;
            end
            kaf_pkg::ACC_P11:     p11_next   = acc_val;
            kaf_pkg::ACC_CAA:     caa_next   = acc_val;
            kaf_pkg::ACC_CAB:     cab_next   = acc_val;
            kaf_pkg::ACC_CBA:     cba_next   = acc_val;
            kaf_pkg::ACC_CBB:     cbb_next   = acc_val;
            kaf_pkg::ACC_BIAS:    bias_next  = acc_val;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
            bias_reg  <= '0;
            caa_reg   <= kaf_pkg::ONE_Q24;
            cab_reg   <= '0;
            cba_reg   <= '0;
            cbb_reg   <= kaf_pkg::ONE_Q24;
        end
        else
        begin
            angle_reg <= angle_next;
            bias_reg  <= bias_next;
            caa_reg   <= caa_next;
            cab_reg   <= cab_next;
            cba_reg   <= cba_next;
            cbb_reg   <= cbb_next;
        end
    end

    // Sample capture, pre-products, innovation, gains and results.
    always_ff @(posedge clk)
    begin
        p00_reg <= p00_next;
        p01_reg <= p01_next;
        p10_reg <= p10_next;
        p11_reg <= p11_next;
        if (cmd.load_in)
        begin
            accel_reg <= accel_angle;
            gyro_reg  <= gyro_rate;
        end
        if (cmd.prep)
        begin
            rate_reg <= rate_diff;
            pdot_reg <= kaf_pkg::sat32(signed'({16'b0, pna_reg}) - 48'(cab_reg)
                                       - 48'(cba_reg));
        end
        if (cmd.calc_err)
        begin
            err_reg <= kaf_pkg::sat32(48'(accel_reg) - 48'(angle_reg));
            e_reg   <= signed'({2'b0, mn_reg}) + 34'(p00_reg);
        end
        if (cmd.gain_load)
        begin
            k0_reg <= quo0;
            k1_reg <= quo1;
        end
        if (cmd.out_load)
        begin
            angle_out_reg <= angle_reg;
            rate_out_reg  <= rate_diff;
        end
    end

    // Gain divider: both covariances over the innovation variance.
    kaf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cmd.div_load),
        .step  (cmd.div_step),
        .den   (e_reg),
        .num0  (p00_reg),
        .num1  (p10_reg),
        .done  (div_done),
        .quo0  (quo0),
        .quo1  (quo1)
    );

    assign status.div_done = div_done;
    assign angle_estimate  = angle_out_reg;
    assign rate_estimate   = rate_out_reg;

endmodule

/* design/kaf_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the Kalman angle fusion block, bound to the top level.
// Depends on kalman_angle_fusion_top for the bind target only.

module kaf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] angle_estimate,
    input logic signed [31:0] rate_estimate
);

    // A result request stays up until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped before it was taken");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(angle_estimate) && $stable(rate_estimate))
        else $error("stalled result payload changed");

    // One sample at a time: the input closes right after an acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request accepted while a sample is in work");

    // A result never appears in the cycle right after an acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result produced without the filter sequence");

endmodule

bind kalman_angle_fusion_top kaf_checker u_kaf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .angle_estimate (angle_estimate),
    .rate_estimate  (rate_estimate)
);
